// ----- rtl/core/laplacian_sharpen_3x3_core_macros.svh -----
// Assertion macros shared by the Laplacian sharpen core.
`ifndef LAPLACIAN_SHARPEN_3X3_CORE_MACROS_SVH
`define LAPLACIAN_SHARPEN_3X3_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define LSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsh: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define LSH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsh: next-cycle check failed");

`endif

// ----- rtl/core/lsh_pkg.sv -----
// Types and constants of the Laplacian sharpen core.
`timescale 1ns / 1ps

package lsh_pkg;

	localparam int MAX_LINE_DEF     = 4096;
	localparam int MAX_CHANNELS_DEF = 4;

	localparam int CFG_W   = 13;   // widest config register
	localparam int CH_W    = 3;    // channel_count register width
	localparam int PIX_W   = 8;

	localparam int LINE_RST  = 1920;
	localparam int ROWS_RST  = 480;
	localparam int CH_RST    = 3;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	typedef enum logic [1:0] {
		REG_LINE_ELEMENTS = 2'd0,
		REG_ROW_COUNT     = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             command;
		logic [PIX_W-1:0] sample;
	} in_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] sharpened;
		logic             frame_end;
	} out_beat_t;

endpackage

// ----- rtl/core/laplacian_sharpen_3x3_core.sv -----
// Five-point Laplacian sharpening core for an interleaved 8-bit raster stream.
// Throughput: one beat per clock each way; the line memory takes one read and one write a beat,
//   and the input stalls only while the output register and both stages are held.
// Path to a result: line memory read and window update (s1), neighbor set (s2), then sum and saturate
//   into the output register; a result trails its sample by line_elements + channel_count beats.
// Reset clears control, counters, window and delays; the line memory stays uninitialized.
`timescale 1ns / 1ps

`include "laplacian_sharpen_3x3_core_macros.svh"

module laplacian_sharpen_3x3_core #(
	parameter int MAX_LINE     = lsh_pkg::MAX_LINE_DEF,
	parameter int MAX_CHANNELS = lsh_pkg::MAX_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [lsh_pkg::CFG_W-1:0]   cfg_data,

	input  logic                        item_valid,
	output logic                        item_ready,
	input  lsh_pkg::in_beat_t           item,

	output logic                        result_valid,
	input  logic                        result_ready,
	output lsh_pkg::out_beat_t          result
);

	localparam int LW      = $clog2(MAX_LINE);                   // column index
	localparam int CW      = $clog2(MAX_LINE + 1);               // row/column counts
	localparam int EW      = CW + 1;                             // compare width
	localparam int FW      = $clog2(MAX_LINE + MAX_CHANNELS + 1);
	localparam int WIN_LEN = 2 * MAX_CHANNELS;
	localparam int PW      = lsh_pkg::PIX_W;
	localparam int MW      = 2 * PW;                             // {upper, middle}

	// ---------------------------------------------------------------
	// Configuration registers. Any write to a mapped register restarts the frame.
	// ---------------------------------------------------------------
	logic [CW-1:0]            line_q;
	logic [CW-1:0]            rows_q;
	logic [lsh_pkg::CH_W-1:0] ch_q;

	logic                     cfg_hit;
	logic [31:0]              cfg_v32;
	logic [31:0]              cfg_ch32;
	logic [CW-1:0]            cfg_len;
	logic [lsh_pkg::CH_W-1:0] cfg_ch;

	always_comb begin
		cfg_v32  = 32'(cfg_data);
		cfg_ch32 = 32'(cfg_data[lsh_pkg::CH_W-1:0]);
		// zero reads as one, oversize saturates
		if (cfg_v32 == 32'd0) begin
			cfg_len = CW'(1);
		end else if (cfg_v32 > 32'(MAX_LINE)) begin
			cfg_len = CW'(MAX_LINE);
		end else begin
			cfg_len = CW'(cfg_v32);
		end
		if (cfg_ch32 == 32'd0) begin
			cfg_ch = lsh_pkg::CH_W'(1);
		end else if (cfg_ch32 > 32'(MAX_CHANNELS)) begin
			cfg_ch = lsh_pkg::CH_W'(MAX_CHANNELS);
		end else begin
			cfg_ch = lsh_pkg::CH_W'(cfg_ch32);
		end
	end

	always_comb begin
		unique case (cfg_index)
			lsh_pkg::REG_LINE_ELEMENTS,
			lsh_pkg::REG_ROW_COUNT,
			lsh_pkg::REG_CHANNEL_COUNT: cfg_hit = cfg_we;
			default:                    cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= CW'(lsh_pkg::LINE_RST);
			rows_q <= CW'(lsh_pkg::ROWS_RST);
			ch_q   <= lsh_pkg::CH_W'(lsh_pkg::CH_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsh_pkg::REG_LINE_ELEMENTS: line_q <= cfg_len;
				lsh_pkg::REG_ROW_COUNT:     rows_q <= cfg_len;
				lsh_pkg::REG_CHANNEL_COUNT: ch_q   <= cfg_ch;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake / stage advance
	//   s1: line memory data back, window and delays update, memory write
	//   s2: neighbor set registered, sum and saturate into output register
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2;
	logic emit_s2;
	logic out_free, adv2, mv1, accept;

	assign out_free   = !result_valid || result_ready;
	assign adv2       = !valid_s2 || !emit_s2 || out_free;
	assign mv1        = valid_s1 && adv2;
	assign item_ready = !valid_s1 || adv2;
	assign accept     = item_valid && item_ready;

	// ---------------------------------------------------------------
	// Stage 0: frame position, pending-result bookkeeping
	// ---------------------------------------------------------------
	logic [LW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [FW-1:0] fed_q;
	logic [LW-1:0] ocol_q;
	logic [LW-1:0] orow_q;

	logic [EW-1:0] col_inc;
	logic          col_wrap;
	logic          row_open;
	logic [PW-1:0] x_now;
	logic [FW-1:0] wch;
	logic          emit_now;
	logic          inside_now;
	logic          last_now;
	logic          ocol_wrap;

	always_comb begin
		col_inc  = EW'(col_q) + EW'(1);
		col_wrap = col_inc >= EW'(line_q);
		row_open = row_q < rows_q;
		// drain, or anything past the last row, feeds zero
		x_now    = (item.command == lsh_pkg::CMD_SAMPLE && row_open) ? item.sample : '0;
		wch      = FW'(line_q) + FW'(ch_q);
		emit_now = fed_q >= wch;
		inside_now = (orow_q != '0)
			&& (EW'(orow_q) + EW'(2) <= EW'(rows_q))
			&& (EW'(ocol_q) >= EW'(ch_q))
			&& (EW'(ocol_q) + EW'(ch_q) + EW'(1) <= EW'(line_q));
		ocol_wrap = EW'(ocol_q) + EW'(1) == EW'(line_q);
		last_now  = ocol_wrap && (EW'(orow_q) + EW'(1) == EW'(rows_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fed_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_hit) begin
			col_q  <= '0;
			row_q  <= '0;
			fed_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (emit_now && last_now) begin
				// last result of the frame: next beat starts a new one
				col_q  <= '0;
				row_q  <= '0;
				fed_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				col_q <= col_wrap ? '0 : LW'(col_inc);
				if (col_wrap && row_open) begin
					row_q <= row_q + CW'(1);
				end
				if (!emit_now) begin
					fed_q <= fed_q + FW'(1);
				end else if (ocol_wrap) begin
					ocol_q <= '0;
					orow_q <= orow_q + LW'(1);
				end else begin
					ocol_q <= ocol_q + LW'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Line memory: {two rows back, one row back} per column.
	// Read at accept, written when the item leaves s1. A read that meets
	// a write to the same column (one-sample rows) takes the forwarded word.
	// ---------------------------------------------------------------
	logic [MW-1:0] line_mem_q [MAX_LINE];
	logic [MW-1:0] rd_s1;
	logic [LW-1:0] col_s1;
	logic [PW-1:0] x_s1;
	logic          emit_s1, inside_s1, last_s1;
	logic          fwd_s1;
	logic [MW-1:0] fwd_data_s1;

	logic [MW-1:0] ent;
	logic [PW-1:0] a_up, b_mid;
	logic [MW-1:0] wr_data;

	assign ent     = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign a_up    = ent[MW-1:PW];
	assign b_mid   = ent[PW-1:0];
	assign wr_data = {b_mid, x_s1};

	always_ff @(posedge clk) begin
		if (mv1) begin
			line_mem_q[col_s1] <= wr_data;
		end
		if (accept) begin
			rd_s1 <= line_mem_q[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= mv1 && (col_s1 == col_q);
		end else if (mv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_q;
			x_s1        <= x_now;
			emit_s1     <= emit_now;
			inside_s1   <= inside_now;
			last_s1     <= last_now;
			fwd_data_s1 <= wr_data;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: middle-row window and the two column delays
	// ---------------------------------------------------------------
	logic [PW-1:0] win_q   [WIN_LEN];
	logic [PW-1:0] updly_q [MAX_CHANNELS];
	logic [PW-1:0] dndly_q [MAX_CHANNELS];

	logic [PW-1:0] cen_n, left_n, up_n, down_n;

	// values as they stand after this beat's shift
	always_comb begin
		cen_n  = '0;
		left_n = '0;
		up_n   = '0;
		down_n = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			if (32'(ch_q) == 32'(i + 1)) begin
				cen_n  = win_q[i];
				up_n   = updly_q[i];
				down_n = dndly_q[i];
			end
		end
		for (int j = 0; j < WIN_LEN; j++) begin
			if (32'(ch_q) * 32'd2 == 32'(j + 1)) begin
				left_n = win_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				updly_q[i] <= '0;
				dndly_q[i] <= '0;
			end
		end else if (mv1) begin
			win_q[0] <= b_mid;
			for (int i = 1; i < WIN_LEN; i++) begin
				win_q[i] <= win_q[i-1];
			end
			// delays only shift over the active channel count
			updly_q[0] <= a_up;
			dndly_q[0] <= x_s1;
			for (int i = 1; i < MAX_CHANNELS; i++) begin
				if (32'(i) < 32'(ch_q)) begin
					updly_q[i] <= updly_q[i-1];
					dndly_q[i] <= dndly_q[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: neighbor set registered
	// ---------------------------------------------------------------
	logic          inside_s2, last_s2;
	logic [PW-1:0] cen_s2, left_s2, right_s2, up_s2, down_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			emit_s2  <= 1'b0;
		end else if (mv1) begin
			valid_s2 <= 1'b1;
			emit_s2  <= emit_s1;
		end else if (adv2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			inside_s2 <= inside_s1;
			last_s2   <= last_s1;
			cen_s2    <= cen_n;
			left_s2   <= left_n;
			right_s2  <= b_mid;
			up_s2     <= up_n;
			down_s2   <= down_n;
		end
	end

	// 5*c - l - r - u - d spans -1020..1275: 12 bits two's complement is exact
	logic signed [11:0] sum_s2;
	logic [PW-1:0]      sat_s2;

	always_comb begin
		sum_s2 = signed'(12'({cen_s2, 2'b00}) + 12'(cen_s2) - 12'(left_s2)
			- 12'(right_s2) - 12'(up_s2) - 12'(down_s2));
		if (sum_s2 < 0) begin
			sat_s2 = '0;
		end else if (sum_s2 > 12'sd255) begin
			sat_s2 = '1;
		end else begin
			sat_s2 = sum_s2[PW-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	lsh_pkg::out_beat_t result_q;
	logic               load_out;

	assign load_out = valid_s2 && emit_s2 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_out) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.sharpened <= inside_s2 ? sat_s2 : '0;
			result_q.frame_end <= last_s2;
		end
	end

	assign result = result_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	logic out_pos_ok, restart_ok;

	assign out_pos_ok = (EW'(ocol_q) < EW'(line_q)) && (EW'(orow_q) < EW'(rows_q));
	assign restart_ok = (ocol_q == '0) && (orow_q == '0) && (fed_q == '0) && (col_q == '0);

	`LSH_ASSERT_IMP(a_col_range, clk, arst_n, 1'b1, EW'(col_q) < EW'(line_q))
	`LSH_ASSERT_IMP(a_out_pos_range, clk, arst_n, 1'b1, out_pos_ok)
	`LSH_ASSERT_IMP(a_fed_cap, clk, arst_n, 1'b1, fed_q <= wch)
	`LSH_ASSERT_NXT(a_frame_restart, clk, arst_n, accept && emit_now && last_now, restart_ok)
	`LSH_ASSERT_IMP(a_s1_room, clk, arst_n, !valid_s1, item_ready)

endmodule

// ----- bench/tb_laplacian_sharpen_3x3_core.sv -----
// Self-checking bench for the five-point Laplacian sharpen core: queued stimulus, scoreboard.
`timescale 1ns / 1ps

module tb_laplacian_sharpen_3x3_core;

	localparam int MAX_LINE   = lsh_pkg::MAX_LINE_DEF;
	localparam int MAX_CH     = lsh_pkg::MAX_CHANNELS_DEF;
	localparam int WIN_DEPTH  = 2 * MAX_CH + 1;
	localparam int STALL_LIMIT = 2000;    // cycles with no beat on either side
	localparam int SETTLE_CYCLES = 8;     // covers the three-stage pipe with margin
	localparam int RANDOM_BEATS = 1800;
	localparam int TALL_BEATS = 64;
	localparam logic [1:0] REG_UNUSED = 2'd3;   // index past the register file

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [1:0]                  cfg_index = '0;
	logic [lsh_pkg::CFG_W-1:0]   cfg_data = '0;
	logic                        item_valid = 1'b0;
	logic                        item_ready;
	lsh_pkg::in_beat_t           item = '0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	lsh_pkg::out_beat_t          result;

	laplacian_sharpen_3x3_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------
	// Shadow of the sharpening datapath. Tracks frame position, both line
	// buffers, the middle-row window and the two column-aligned delays that
	// hand back the upper and lower neighbour of the centre sample.
	// ------------------------------------------------------------------
	int unsigned line_len = lsh_pkg::LINE_RST;
	int unsigned rows     = lsh_pkg::ROWS_RST;
	int unsigned chans    = lsh_pkg::CH_RST;

	bit [7:0] upper_mem [MAX_LINE];
	bit [7:0] middle_mem [MAX_LINE];
	bit [7:0] win [WIN_DEPTH];
	bit [7:0] tap_dly [2][MAX_CH];    // [0] upper neighbour, [1] lower neighbour
	int unsigned row_pos, col_pos, sent_cnt, fed_cnt;

	lsh_pkg::out_beat_t expected_pixels[$];
	lsh_pkg::in_beat_t  pending_beats[$];

	int unsigned mismatch_count, results_checked, frame_ends, beats_queued, beats_taken;
	int unsigned settings_written, idle_cycles;
	int unsigned send_idle_pct, recv_idle_pct;
	logic               item_fire = 1'b0;
	lsh_pkg::out_beat_t want;

	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void restart_frame();
		row_pos  = 0;
		col_pos  = 0;
		sent_cnt = 0;
		fed_cnt  = 0;
	endfunction

	// Register write: out-of-range values clamp, any write to a mapped register restarts the frame.
	function automatic void apply_register(logic [1:0] idx, logic [lsh_pkg::CFG_W-1:0] val);
		unique case (idx)
			lsh_pkg::REG_LINE_ELEMENTS: begin
				line_len = clamp_reg(val, MAX_LINE);
				restart_frame();
			end
			lsh_pkg::REG_ROW_COUNT: begin
				rows = clamp_reg(val, MAX_LINE);
				restart_frame();
			end
			lsh_pkg::REG_CHANNEL_COUNT: begin
				chans = clamp_reg(val[lsh_pkg::CH_W-1:0], MAX_CH);
				restart_frame();
			end
			default: ;
		endcase
	endfunction

	// Delay line of 'chans' stages; returns what went in 'chans' beats ago.
	function automatic bit [7:0] shift_tap(int which, bit [7:0] v);
		bit [7:0] old;
		old = tap_dly[which][chans-1];
		for (int i = MAX_CH - 1; i > 0; i--)
			if (i < chans)
				tap_dly[which][i] = tap_dly[which][i-1];
		tap_dly[which][0] = v;
		return old;
	endfunction

	function automatic void predict_sharpened(lsh_pkg::in_beat_t b);
		int unsigned        col, orow, ocol;
		bit [7:0]           x, a, m, up, dn, ctr, lft, rgt;
		int                 s;
		lsh_pkg::out_beat_t r;
		col = (col_pos >= line_len) ? 0 : col_pos;
		// drains, and samples past the frame's last row, feed zero
		x = (b.command == lsh_pkg::CMD_SAMPLE && row_pos < rows) ? b.sample : 8'd0;
		a = upper_mem[col];
		m = middle_mem[col];
		upper_mem[col]  = m;
		middle_mem[col] = x;
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			win[i] = win[i-1];
		win[0] = m;
		up  = shift_tap(0, a);
		dn  = shift_tap(1, x);
		ctr = win[chans];
		lft = win[2*chans];
		rgt = win[0];
		col++;
		if (col >= line_len) begin
			col = 0;
			if (row_pos < rows)
				row_pos++;
		end
		col_pos = col;
		fed_cnt++;
		// nothing comes out until more than one row plus one pixel has gone in
		if (fed_cnt <= line_len + chans)
			return;
		orow = sent_cnt / line_len;
		ocol = sent_cnt % line_len;
		r.sharpened = '0;
		if (orow >= 1 && orow + 2 <= rows && ocol >= chans && ocol + chans + 1 <= line_len) begin
			s = 5 * int'(ctr) - int'(lft) - int'(rgt) - int'(up) - int'(dn);
			r.sharpened = (s < 0) ? 8'd0 : (s > 255) ? 8'd255 : s[7:0];
		end
		sent_cnt++;
		r.frame_end = (sent_cnt >= line_len * rows);
		expected_pixels.push_back(r);
		if (r.frame_end)
			restart_frame();
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Driver: one beat at a time from pending_beats, launched on the falling
	// edge. valid holds with a stable payload until the core takes the beat.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_fire)) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item       <= pending_beats.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		result_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Monitor: results are checked before the same-edge input beat is fed to
	// the shadow model, so a beat never predicts a result it could not cause.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			item_fire <= 1'b0;
		end else begin
			item_fire <= item_valid && item_ready;
			if (result_valid && result_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected result sharpened=%0d frame_end=%0b",
						result.sharpened, result.frame_end));
				end else begin
					want = expected_pixels.pop_front();
					if (result.sharpened !== want.sharpened)
						report_mismatch($sformatf("result %0d sharpened got %0d want %0d",
							results_checked, result.sharpened, want.sharpened));
					if (result.frame_end !== want.frame_end)
						report_mismatch($sformatf("result %0d frame_end got %b want %b",
							results_checked, result.frame_end, want.frame_end));
					if (want.frame_end)
						frame_ends++;
					results_checked++;
				end
			end
			if (item_valid && item_ready) begin
				predict_sharpened(item);
				beats_taken++;
			end
		end
	end

	// Watchdog: any beat on either channel resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
					STALL_LIMIT, expected_pixels.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_beat(logic cmd, logic [7:0] v);
		lsh_pkg::in_beat_t b;
		b.command = cmd;
		b.sample  = v;
		pending_beats.push_back(b);
		beats_queued++;
	endtask

	// Skewed toward the rails so both saturation limits get hit often.
	function automatic logic [7:0] pixel_value();
		int unsigned k;
		k = $urandom_range(7);
		if (k == 0)
			return 8'd0;
		if (k == 1)
			return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	// Core is idle once every queued beat went in, every result came back,
	// and beats that release nothing have had time to leave the pipe.
	task automatic wait_idle();
		while (pending_beats.size() != 0 || item_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Back-to-back writes keep cfg_we high across them; only index/data move.
	task automatic write_registers(logic [lsh_pkg::CFG_W-1:0] lv, logic [lsh_pkg::CFG_W-1:0] rv,
			logic [lsh_pkg::CFG_W-1:0] cv, bit poke_unused);
		logic [lsh_pkg::CFG_W-1:0] junk;
		junk = lsh_pkg::CFG_W'($urandom);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= lsh_pkg::REG_LINE_ELEMENTS;
		cfg_data  <= lv;
		apply_register(lsh_pkg::REG_LINE_ELEMENTS, lv);
		@(negedge clk);
		cfg_index <= lsh_pkg::REG_ROW_COUNT;
		cfg_data  <= rv;
		apply_register(lsh_pkg::REG_ROW_COUNT, rv);
		@(negedge clk);
		cfg_index <= lsh_pkg::REG_CHANNEL_COUNT;
		cfg_data  <= cv;
		apply_register(lsh_pkg::REG_CHANNEL_COUNT, cv);
		if (poke_unused) begin
			// write to an unmapped index must change nothing
			@(negedge clk);
			cfg_index <= REG_UNUSED;
			cfg_data  <= junk;
			apply_register(REG_UNUSED, junk);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_written++;
	endtask

	// One frame plus its flush. 'noisy' swaps in drains mid-frame and samples
	// in the flush; 'cut' stops early so the next register write drops the rest.
	task automatic queue_frame(bit noisy, bit cut);
		int unsigned n, flush, stop;
		bit          drain_here;
		n     = line_len * rows;
		flush = line_len + chans;
		stop  = cut ? $urandom_range(n + flush - 1) : n + flush;
		for (int unsigned i = 0; i < stop; i++) begin
			if (i < n)
				drain_here = noisy && ($urandom_range(31) == 0);
			else
				drain_here = !(noisy && ($urandom_range(5) == 0));
			push_beat(drain_here ? lsh_pkg::CMD_DRAIN : lsh_pkg::CMD_SAMPLE, pixel_value());
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned random_base, done, frames;
		logic [lsh_pkg::CFG_W-1:0] lv, rv, cv;

		send_idle_pct = 19;
		recv_idle_pct = 52;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero registers read as one: a single-sample frame whose neighbour
		// distance spans the whole row. Sample after the last sample is
		// discarded; the drain then releases the one result (border, zero).
		write_registers('0, '0, '0, 1'b0);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd255);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd170);
		push_beat(lsh_pkg::CMD_DRAIN, 8'd85);
		wait_idle();

		// 3x4, one channel: interior of row 1 saturates high, row 2 low.
		// A drain stands in for a sample in the last row.
		write_registers(13'd3, 13'd4, 13'd1, 1'b0);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd0);   push_beat(lsh_pkg::CMD_SAMPLE, 8'd0);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd0);   push_beat(lsh_pkg::CMD_SAMPLE, 8'd0);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd255); push_beat(lsh_pkg::CMD_SAMPLE, 8'd0);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd255); push_beat(lsh_pkg::CMD_SAMPLE, 8'd0);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd255); push_beat(lsh_pkg::CMD_DRAIN, 8'd9);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd200); push_beat(lsh_pkg::CMD_SAMPLE, 8'd7);
		push_beat(lsh_pkg::CMD_SAMPLE, 8'd1);   push_beat(lsh_pkg::CMD_DRAIN, 8'd0);
		push_beat(lsh_pkg::CMD_DRAIN, 8'd0);    push_beat(lsh_pkg::CMD_DRAIN, 8'd255);
		wait_idle();

		// Random settings, mostly clean frames with random content, some noisy
		// or cut short. Idle profile rotates by progress through this part.
		random_base = beats_queued;
		done = 0;
		while (done < RANDOM_BEATS) begin
			if (done >= 2 * RANDOM_BEATS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (done >= RANDOM_BEATS / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 19;
			end
			lv = lsh_pkg::CFG_W'($urandom_range(24, 1));
			rv = lsh_pkg::CFG_W'($urandom_range(8, 1));
			cv = lsh_pkg::CFG_W'($urandom_range(4, 1));
			case ($urandom_range(9))
				0: cv = lsh_pkg::CFG_W'($urandom_range(7, 5));   // saturates to max channels
				1: lv = '0;
				2: rv = '0;
				default: ;
			endcase
			write_registers(lv, rv, cv, $urandom_range(7) == 0);
			frames = $urandom_range(3, 1);
			for (int f = 0; f < frames; f++)
				queue_frame($urandom_range(3) == 0, f == frames - 1 && $urandom_range(4) == 0);
			wait_idle();
			done = beats_queued - random_base;
		end

		// Tallest frame (all-ones row count saturates), one sample per row:
		// every result sits on the border and none ends the frame.
		write_registers(13'd1, '1, 13'd4, 1'b0);
		for (int i = 0; i < TALL_BEATS; i++)
			push_beat(lsh_pkg::CMD_SAMPLE, pixel_value());
		wait_idle();

		$display("Covered %0d input beats under %0d register settings; %0d results checked",
			beats_taken, settings_written, results_checked);
		$display("across %0d completed frames, %0d mismatches", frame_ends, mismatch_count);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lsh_pkg.sv
rtl/core/laplacian_sharpen_3x3_core.sv
bench/tb_laplacian_sharpen_3x3_core.sv
